>>> hw/rtl/selective_repeat_sender_window_macros.svh
// Assertion macros for the selective-repeat sender window.
// Used by modules that have clk_i and rst_ni in scope.
`ifndef SELECTIVE_REPEAT_SENDER_WINDOW_MACROS_SVH
`define SELECTIVE_REPEAT_SENDER_WINDOW_MACROS_SVH

// Plain check, sampled on clk_i, off during reset.
`define SRSW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication check, sampled on clk_i, off during reset.
`define SRSW_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/srsw_pkg.sv
// Shared types and constants for the selective-repeat sender window.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package srsw_pkg;

  localparam int unsigned ResultLimit = 16;

  localparam logic [7:0] TotalReset  = 8'd8;
  localparam logic [4:0] WindowReset = 5'd4;

  typedef enum logic [0:0] {
    REG_TOTAL  = 1'b0,
    REG_WINDOW = 1'b1
  } cfg_reg_e;

  typedef enum logic [0:0] {
    KIND_START = 1'b0,
    KIND_ACK   = 1'b1
  } item_kind_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_SKIP
  } ctrl_state_e;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_CLEAR,
    CMD_LOAD,
    CMD_BURST,
    CMD_ACK,
    CMD_SKIP
  } dp_cmd_e;

  typedef struct packed {
    logic clear_done;
    logic kind;
    logic burst_end;
    logic ack_ooo;
    logic skip_more;
  } dp_status_t;

endpackage

`default_nettype wire

>>> hw/rtl/srsw_ctrl.sv
// Controller state machine for the selective-repeat sender window.
// Depends on srsw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module srsw_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  input  wire srsw_pkg::dp_status_t status_i,
  output srsw_pkg::dp_cmd_e       cmd_o,
  output logic                    busy_o
);
  import srsw_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (status_i.clear_done) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (status_i.kind == KIND_START) begin
          if (status_i.burst_end) state_d = ST_IDLE;
        end else if (status_i.ack_ooo) begin
          state_d = ST_SKIP;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_SKIP: begin
        if (!status_i.skip_more) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o  = CMD_NONE;
    busy_o = 1'b1;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o = CMD_CLEAR;
      end
      ST_IDLE: begin
        busy_o = 1'b0;
        if (start) cmd_o = CMD_LOAD;
      end
      ST_EXEC: begin
        cmd_o = (status_i.kind == KIND_START) ? CMD_BURST : CMD_ACK;
      end
      ST_SKIP: begin
        cmd_o = CMD_SKIP;
      end
      default: begin
        cmd_o  = CMD_NONE;
        busy_o = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> hw/rtl/srsw_datapath.sv
// Datapath for the selective-repeat sender window: config, counters, mark bitmap, result.
// Depends on srsw_pkg and selective_repeat_sender_window_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "selective_repeat_sender_window_macros.svh"

module srsw_datapath #(
  parameter int unsigned MAX_FRAMES = 255,
  parameter int unsigned MAX_WINDOW = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [0:0]          cfg_index_i,
  input  wire logic [7:0]          cfg_data_i,
  input  wire logic                kind_i,
  input  wire logic [7:0]          ack_number_i,
  input  wire srsw_pkg::dp_cmd_e   cmd_i,
  output srsw_pkg::dp_status_t     status_o,
  output logic                     result_valid_o,
  output logic                     sends_frame_o,
  output logic [7:0]               frame_number_o,
  output logic                     is_retransmit_o,
  output logic [8:0]               expected_ack_o,
  output logic                     all_acked_o,
  output logic                     last_o
);
  import srsw_pkg::*;

  localparam int unsigned IdxW      = $clog2(MAX_FRAMES + 1);
  localparam int unsigned MarkDepth = 1 << IdxW;
  localparam int unsigned WinCap    = (MAX_WINDOW < ResultLimit) ? MAX_WINDOW : ResultLimit;
  localparam logic [7:0]  MaxTotal  = 8'(MAX_FRAMES);
  localparam logic [4:0]  MaxWin    = 5'(WinCap);
  localparam logic [IdxW-1:0] ClrLast = IdxW'(MarkDepth - 1);

  logic [7:0] total_q;
  logic [4:0] window_q;
  logic       kind_q;
  logic [7:0] ack_q;
  logic [8:0] next_q, next_d;
  logic [8:0] exp_q, exp_d;
  logic [7:0] resend_q, resend_d;
  logic [IdxW-1:0] clr_q, clr_d;

  // mark memory, one entry written and one read per cycle
  logic            mark_mem [MarkDepth];
  logic            mark_rd_q;
  logic            mark_we;
  logic [IdxW-1:0] mark_wa;
  logic            mark_wd;
  logic [IdxW-1:0] rd_addr;

  logic       valid_q, valid_d;
  logic       sends_q, sends_d;
  logic [7:0] frame_q, frame_d;
  logic       retx_q, retx_d;
  logic [8:0] expack_q, expack_d;
  logic       all_q, all_d;
  logic       last_q, last_d;

  logic [7:0] total_eff;
  logic [8:0] total9;
  logic [8:0] win9;
  logic       burst_has;
  logic       over;
  logic       ack_in_order;
  logic       ack_in_range;
  logic       skip_more;
  logic [8:0] exp_inc;
  logic [IdxW-1:0] exp_idx;
  logic [IdxW-1:0] ack_idx;

  assign total_eff    = (total_q > MaxTotal) ? MaxTotal : total_q;
  assign total9       = {1'b0, total_eff};
  assign win9         = {4'b0, (window_q > MaxWin) ? MaxWin : window_q};
  assign burst_has    = next_q <= win9;
  assign over         = exp_q > total9;
  assign ack_in_order = {1'b0, ack_q} <= exp_q;
  assign ack_in_range = (ack_q != 8'd0) && (ack_q <= total_eff);
  assign exp_inc      = exp_q + 9'd1;
  assign exp_idx      = exp_q[IdxW-1:0];
  assign ack_idx      = ack_q[IdxW-1:0];
  // mark_rd_q always holds the mark of the current expected frame
  assign skip_more    = !over && mark_rd_q;
  assign rd_addr      = exp_d[IdxW-1:0];

  assign status_o.clear_done = (clr_q == ClrLast);
  assign status_o.kind       = kind_q;
  assign status_o.burst_end  = !burst_has || (next_q == win9);
  assign status_o.ack_ooo    = !over && !ack_in_order;
  assign status_o.skip_more  = skip_more;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q  <= TotalReset;
      window_q <= WindowReset;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_TOTAL:  total_q  <= cfg_data_i;
        REG_WINDOW: window_q <= cfg_data_i[4:0];
        default:    total_q  <= total_q;
      endcase
    end
  end

  always_comb begin
    next_d   = next_q;
    exp_d    = exp_q;
    resend_d = resend_q;
    clr_d    = clr_q;
    mark_we  = 1'b0;
    mark_wa  = '0;
    mark_wd  = 1'b1;
    valid_d  = 1'b0;
    sends_d  = 1'b0;
    frame_d  = 8'd0;
    retx_d   = 1'b0;
    expack_d = exp_q;
    all_d    = over;
    last_d   = 1'b1;
    unique case (cmd_i)
      CMD_CLEAR: begin
        mark_we = 1'b1;
        mark_wa = clr_q;
        mark_wd = 1'b0;
        clr_d   = clr_q + 1'b1;
      end
      CMD_BURST: begin
        valid_d = 1'b1;
        if (burst_has) begin
          sends_d = 1'b1;
          frame_d = next_q[7:0];
          last_d  = (next_q == win9);
          next_d  = next_q + 9'd1;
        end
      end
      CMD_ACK: begin
        if (over) begin
          valid_d = 1'b1;
        end else if (ack_in_order) begin
          valid_d  = 1'b1;
          mark_we  = 1'b1;
          mark_wa  = exp_idx;
          exp_d    = exp_inc;
          expack_d = exp_inc;
          all_d    = exp_inc > total9;
          if (next_q <= total9) begin
            sends_d = 1'b1;
            frame_d = next_q[7:0];
            next_d  = next_q + 9'd1;
          end
        end else begin
          if (ack_in_range) begin
            mark_we = 1'b1;
            mark_wa = ack_idx;
          end
          resend_d = exp_q[7:0];
          exp_d    = exp_inc;
        end
      end
      CMD_SKIP: begin
        if (skip_more) begin
          exp_d = exp_inc;
        end else begin
          valid_d = 1'b1;
          sends_d = 1'b1;
          frame_d = resend_q;
          retx_d  = 1'b1;
        end
      end
      CMD_NONE, CMD_LOAD: begin
        valid_d = 1'b0;
      end
      default: valid_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_q  <= 9'd1;
      exp_q   <= 9'd1;
      clr_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      next_q  <= next_d;
      exp_q   <= exp_d;
      clr_q   <= clr_d;
      valid_q <= valid_d;
    end
  end

  // write-first read of the mark at the next expected frame
  always_ff @(posedge clk_i) begin
    if (mark_we) mark_mem[mark_wa] <= mark_wd;
    mark_rd_q <= (mark_we && (mark_wa == rd_addr)) ? mark_wd : mark_mem[rd_addr];
  end

  // transfer payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (cmd_i == CMD_LOAD) begin
      kind_q <= kind_i;
      ack_q  <= ack_number_i;
    end
    resend_q <= resend_d;
    sends_q  <= sends_d;
    frame_q  <= frame_d;
    retx_q   <= retx_d;
    expack_q <= expack_d;
    all_q    <= all_d;
    last_q   <= last_d;
  end

  assign result_valid_o  = valid_q;
  assign sends_frame_o   = sends_q;
  assign frame_number_o  = frame_q;
  assign is_retransmit_o = retx_q;
  assign expected_ack_o  = expack_q;
  assign all_acked_o     = all_q;
  assign last_o          = last_q;

  `SRSW_ASSERT(a_exp_monotonic, 1'b1 |=> (exp_q >= $past(exp_q)), "expected frame went backwards")
  `SRSW_ASSERT_IMP(a_retx_sends, valid_q && retx_q, sends_q && last_q, "retransmit without a frame")
  `SRSW_ASSERT_IMP(a_skip_only_marked, cmd_i == CMD_SKIP && skip_more, !over, "skip past total")

endmodule

`default_nettype wire

>>> hw/rtl/selective_repeat_sender_window.sv
// Top level of the selective-repeat ARQ sender window.
// Depends on srsw_pkg, srsw_ctrl and srsw_datapath.
//
// Usage:
//   Command channel: an item (kind_i, ack_number_i) is taken at a clock edge with
//   start high and busy low. kind 0 starts the burst, kind 1 reports an ack.
//   Result channel: result_valid_o strobes each result for one cycle; the
//   receiver cannot stall, so every strobe is a completed transfer. last_o marks
//   the final result of an item.
//   Config port: cfg_we_i writes cfg_data_i into register cfg_index_i
//   (0 total frames, 1 window size) in the same edge; write only while idle.
// Timing:
//   A start item gives one result per cycle, registered out of the execute
//   state entered on acceptance, up to 16 in a row; busy is low again with
//   the last result. An in-order ack, or any ack after completion, gives one
//   result, registered out of the execute state. An out-of-order ack walks the
//   mark memory one frame per cycle past already acknowledged frames, then retransmits.
// Reset loads register defaults (8 frames, window 4) and the counters; then a
// clearing pass zeroes all 2**clog2(MAX_FRAMES+1) mark memory entries (256 by
// default), one entry a cycle, with busy held high.
`timescale 1ns / 1ps
`default_nettype none

module selective_repeat_sender_window #(
  parameter int unsigned MAX_FRAMES = 255,
  parameter int unsigned MAX_WINDOW = 16
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [0:0] cfg_index_i,
  input  wire logic [7:0] cfg_data_i,
  input  wire logic       start,
  output logic            busy,
  input  wire logic       kind_i,
  input  wire logic [7:0] ack_number_i,
  output logic            result_valid_o,
  output logic            sends_frame_o,
  output logic [7:0]      frame_number_o,
  output logic            is_retransmit_o,
  output logic [8:0]      expected_ack_o,
  output logic            all_acked_o,
  output logic            last_o
);
  import srsw_pkg::*;

  dp_cmd_e    cmd;
  dp_status_t status;

  srsw_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy)
  );

  srsw_datapath #(
    .MAX_FRAMES (MAX_FRAMES),
    .MAX_WINDOW (MAX_WINDOW)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .kind_i          (kind_i),
    .ack_number_i    (ack_number_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .result_valid_o  (result_valid_o),
    .sends_frame_o   (sends_frame_o),
    .frame_number_o  (frame_number_o),
    .is_retransmit_o (is_retransmit_o),
    .expected_ack_o  (expected_ack_o),
    .all_acked_o     (all_acked_o),
    .last_o          (last_o)
  );

endmodule

`default_nettype wire

>>> dv/tb_selective_repeat_sender_window.sv
// Testbench for selective_repeat_sender_window: drives start and ack items, predicts
// every result from its own window model and checks each strobed result in order.
// Depends on srsw_pkg and the selective_repeat_sender_window RTL.
`timescale 1ns / 1ps

module tb_selective_repeat_sender_window;
  import srsw_pkg::*;

  localparam int unsigned MaxFrames  = 255;
  localparam int unsigned MaxWindow  = 16;
  localparam int unsigned CycleLimit = 300000;

  typedef struct packed {
    logic       sends;
    logic [7:0] frame;
    logic       retx;
    logic [8:0] exp_ack;
    logic       done;
    logic       last;
  } frame_result_t;

  logic       clk_i    = 1'b0;
  logic       rst_ni   = 1'b0;
  logic       cfg_we_i = 1'b0;
  cfg_reg_e   cfg_index_i = REG_TOTAL;
  logic [7:0] cfg_data_i  = '0;
  logic       start    = 1'b0;
  logic       busy;
  item_kind_e kind_i   = KIND_START;
  logic [7:0] ack_number_i = '0;
  logic       result_valid_o;
  logic       sends_frame_o;
  logic [7:0] frame_number_o;
  logic       is_retransmit_o;
  logic [8:0] expected_ack_o;
  logic       all_acked_o;
  logic       last_o;

  // window model
  logic [7:0]  total_reg  = TotalReset;
  logic [4:0]  window_reg = WindowReset;
  int unsigned sent_next  = 1;
  int unsigned exp_frame  = 1;
  bit          acked [256];

  frame_result_t results_due[$];
  int unsigned   mismatches  = 0;
  int unsigned   cycles      = 0;
  int unsigned   idle_pct    = 27;

  selective_repeat_sender_window #(
    .MAX_FRAMES(MaxFrames),
    .MAX_WINDOW(MaxWindow)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .start          (start),
    .busy           (busy),
    .kind_i         (kind_i),
    .ack_number_i   (ack_number_i),
    .result_valid_o (result_valid_o),
    .sends_frame_o  (sends_frame_o),
    .frame_number_o (frame_number_o),
    .is_retransmit_o(is_retransmit_o),
    .expected_ack_o (expected_ack_o),
    .all_acked_o    (all_acked_o),
    .last_o         (last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic int unsigned session_total();
    return (total_reg > MaxFrames) ? MaxFrames : total_reg;
  endfunction

  function automatic int unsigned burst_limit();
    int unsigned w;
    w = window_reg;
    if (w > MaxWindow) w = MaxWindow;
    if (w > ResultLimit) w = ResultLimit;
    return w;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [8:0] got, input logic [8:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  task automatic push_result(input logic sends, input int unsigned frame, input logic retx,
                             input logic last);
    frame_result_t r;
    r.sends   = sends;
    r.frame   = frame[7:0];
    r.retx    = retx;
    r.exp_ack = exp_frame[8:0];
    r.done    = exp_frame > session_total();
    r.last    = last;
    results_due.push_back(r);
  endtask

  task automatic advance_window(input item_kind_e k, input logic [7:0] an);
    int unsigned total;
    int unsigned burst;
    int unsigned resend;
    total = session_total();
    if (k == KIND_START) begin
      burst = burst_limit();
      if (sent_next > burst) push_result(1'b0, 0, 1'b0, 1'b1);
      while (sent_next <= burst) begin
        push_result(1'b1, sent_next, 1'b0, sent_next == burst);
        sent_next++;
      end
    end else if (exp_frame > total) begin
      push_result(1'b0, 0, 1'b0, 1'b1);
    end else if (an <= exp_frame) begin
      acked[exp_frame % 256] = 1'b1;
      exp_frame++;
      if (sent_next <= total) begin
        sent_next++;
        push_result(1'b1, sent_next - 1, 1'b0, 1'b1);
      end else begin
        push_result(1'b0, 0, 1'b0, 1'b1);
      end
    end else begin
      resend = exp_frame;
      if (an >= 1 && an <= total) acked[an] = 1'b1;
      exp_frame++;
      while (exp_frame <= total && acked[exp_frame % 256]) exp_frame++;
      push_result(1'b1, resend, 1'b1, 1'b1);
    end
  endtask

  always @(posedge clk_i) begin
    frame_result_t want;
    if (rst_ni && result_valid_o) begin
      if (results_due.size() == 0) begin
        report_mismatch($sformatf("result with none due, frame %0d", frame_number_o));
      end else begin
        want = results_due.pop_front();
        check_field("sends_frame", sends_frame_o, want.sends);
        check_field("frame_number", frame_number_o, want.frame);
        check_field("is_retransmit", is_retransmit_o, want.retx);
        check_field("expected_ack", expected_ack_o, want.exp_ack);
        check_field("all_acked", all_acked_o, want.done);
        check_field("last", last_o, want.last);
      end
    end
  end

  // start is left high when the next transfer follows straight on
  task automatic send_item(input item_kind_e k, input logic [7:0] an);
    start        <= 1'b1;
    kind_i       <= k;
    ack_number_i <= an;
    do @(posedge clk_i); while (busy);
    advance_window(k, an);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk_i); while (results_due.size() != 0 || busy);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [7:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_TOTAL) total_reg = val;
    else window_reg = val[4:0];
    @(posedge clk_i);
  endtask

  task automatic test_reset_burst();
    send_item(KIND_START, 8'd0);
    send_item(KIND_START, 8'd255);
    wait_idle();
  endtask

  task automatic test_window_extremes();
    write_reg(REG_WINDOW, 8'd0);
    send_item(KIND_START, 8'd0);
    wait_idle();
    write_reg(REG_WINDOW, 8'd16);
    send_item(KIND_START, 8'd170);
    wait_idle();
    write_reg(REG_WINDOW, 8'd31);
    send_item(KIND_START, 8'd85);
    wait_idle();
  endtask

  // default total of 8: in-order, ack 0, marks ahead, out of range, skip to completion
  task automatic test_ack_cases();
    send_item(KIND_ACK, 8'd1);
    send_item(KIND_ACK, 8'd0);
    send_item(KIND_ACK, 8'd6);
    send_item(KIND_ACK, 8'd200);
    send_item(KIND_ACK, 8'd5);
    send_item(KIND_ACK, 8'd8);
    send_item(KIND_ACK, 8'd3);
    send_item(KIND_START, 8'd0);
    wait_idle();
  endtask

  task automatic test_total_extremes();
    write_reg(REG_TOTAL, 8'd0);
    send_item(KIND_ACK, 8'd0);
    wait_idle();
    write_reg(REG_TOTAL, 8'd1);
    send_item(KIND_ACK, 8'd255);
    wait_idle();
    write_reg(REG_TOTAL, 8'd255);
    write_reg(REG_WINDOW, 8'd1);
    send_item(KIND_ACK, 8'd255);
    send_item(KIND_ACK, 8'd9);
    wait_idle();
  endtask

  // mostly in-order acks and near-ahead acks that build marks, some noise
  task automatic test_random_phase(input int unsigned pct, input logic [7:0] total,
                                   input logic [7:0] window);
    int unsigned pick;
    int unsigned ahead;
    int unsigned count;
    logic [7:0]  an;
    write_reg(REG_TOTAL, total);
    write_reg(REG_WINDOW, window);
    idle_pct = pct;
    count = 0;
    while (exp_frame <= session_total() && count < 300) begin
      pick = $urandom_range(99);
      if (pick < 5) begin
        send_item(KIND_START, 8'($urandom_range(255)));
      end else begin
        if (pick < 50) begin
          an = exp_frame[7:0];
        end else if (pick < 60) begin
          an = 8'($urandom_range(exp_frame));
        end else if (pick < 88) begin
          ahead = exp_frame + $urandom_range(1, 6);
          an = (ahead > 255) ? 8'd255 : ahead[7:0];
        end else begin
          an = 8'($urandom_range(255));
        end
        send_item(KIND_ACK, an);
      end
      count++;
      if (count == 20 || $urandom_range(99) < 3) wait_idle();
    end
    send_item(KIND_ACK, 8'($urandom_range(255)));
    send_item(KIND_START, 8'($urandom_range(255)));
    wait_idle();
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_burst();
    test_window_extremes();
    test_ack_cases();
    test_total_extremes();
    test_random_phase(27, 8'd90, 8'd16);
    test_random_phase(69, 8'd180, 8'd1);
    test_random_phase(0, 8'd255, 8'd31);
    wait_idle();
    repeat (20) @(posedge clk_i);
    if (results_due.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", results_due.size()));
    if (mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/srsw_pkg.sv
hw/rtl/srsw_ctrl.sv
hw/rtl/srsw_datapath.sv
hw/rtl/selective_repeat_sender_window.sv
dv/tb_selective_repeat_sender_window.sv
